// File: sv/gregorian_date_add_days_assert.svh
// ----------------------------------------------------------------------------
// Gregorian date adder assertion macros
// Shared property wrappers clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DATE_ADD_DAYS_ASSERT_SVH
`define GREGORIAN_DATE_ADD_DAYS_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GDA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// The expression must never be true.
`define GDA_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`endif

// File: sv/gda_pkg.sv
// ----------------------------------------------------------------------------
// Gregorian date adder package
// Field widths, calendar constants, month length lookup and the command and
// status bundles passed between controller and datapath.
// ----------------------------------------------------------------------------
package gda_pkg;

  localparam int MonthW = 4;
  localparam int DayW   = 5;
  localparam int YearW  = 14;
  localparam int DaysW  = 16;
  localparam int CentW  = 8;
  localparam int YicW   = 7;

  localparam logic [MonthW-1:0] JAN = 4'd1;
  localparam logic [MonthW-1:0] FEB = 4'd2;
  localparam logic [MonthW-1:0] DEC = 4'd12;
  localparam logic [DayW-1:0]   LAST_DAY_DEC = 5'd31;
  localparam logic [YearW-1:0]  MAX_YEAR = 14'd9999;
  localparam logic [YicW-1:0]   LAST_YIC = 7'd99;
  localparam logic [YicW-1:0]   CENTURY  = 7'd100;

  // year / 100 as (year * RECIP_100) >> RECIP_SHIFT, exact for any 14-bit year.
  localparam int RecipW      = 13;
  localparam int RECIP_SHIFT = 19;
  localparam logic [RecipW-1:0] RECIP_100 = 13'd5243;
  localparam int ProdW = YearW + RecipW;

  typedef struct packed {
    logic load;   // capture the incoming word
    logic split;  // derive year within century
    logic check;  // validate the starting date
    logic step;   // advance by one month or land in the current one
  } gda_cmd_t;

  typedef struct packed {
    logic bad;       // starting date was invalid
    logic rem_zero;  // no days left to add
  } gda_sts_t;

  typedef struct packed {
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [YearW-1:0]  year;
    logic              bad;
    logic              ovf;
  } gda_res_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SPLIT = 5'b00010,
    ST_CHECK = 5'b00100,
    ST_WALK  = 5'b01000,
    ST_DONE  = 5'b10000
  } gda_state_t;

  // Days in a month; codes outside 1..12 give 31 and are rejected elsewhere.
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [DayW-1:0] len;
    case (m)
      FEB:                       len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// File: sv/gda_ctrl.sv
// ----------------------------------------------------------------------------
// Gregorian date adder controller
// Sequences capture, century split, validation and the month walk.
// ----------------------------------------------------------------------------
module gda_ctrl import gda_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     out_free,
  input  gda_sts_t sts,
  output gda_cmd_t cmd,
  output logic     emit
);

  gda_state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    emit      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        cmd.split = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (sts.bad || sts.rem_zero) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_DONE: begin
        // Hand the result over once the output register has room.
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: sv/gda_dp.sv
// ----------------------------------------------------------------------------
// Gregorian date adder datapath
// Holds the running date and day count and advances one month per step.
// ----------------------------------------------------------------------------
module gda_dp import gda_pkg::*; (
  input  logic              clk,
  input  gda_cmd_t          cmd,
  input  logic [MonthW-1:0] in_month,
  input  logic [DayW-1:0]   in_day,
  input  logic [YearW-1:0]  in_year,
  input  logic [DaysW-1:0]  in_days,
  output gda_sts_t          sts,
  output gda_res_t          res
);

  logic [MonthW-1:0] month_r;
  logic [DayW-1:0]   day_r;
  logic [YearW-1:0]  year_r;
  logic [DaysW-1:0]  rem_r;
  logic [CentW-1:0]  cent_r;
  logic [YicW-1:0]   yic_r;
  logic              bad_r;
  logic              ovf_r;

  logic [ProdW-1:0]  cent_prod;
  logic [YearW-1:0]  yic_diff;
  logic              leap;
  logic [DayW-1:0]   mlen;
  logic [DayW-1:0]   left;
  logic              date_bad;

  assign cent_prod = ProdW'(in_year) * ProdW'(RECIP_100);
  assign yic_diff  = year_r - YearW'(cent_r) * YearW'(CENTURY);

  // Leap: divisible by 4, and either not a century or a century divisible by 4.
  assign leap = (year_r[1:0] == 2'b00) && ((yic_r != '0) || (cent_r[1:0] == 2'b00));
  assign mlen = month_len(month_r, leap);
  assign left = mlen - day_r;

  assign date_bad = (month_r < JAN) || (month_r > DEC) || (year_r > MAX_YEAR) ||
                    (day_r == '0) || (day_r > mlen);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      month_r <= in_month;
      day_r   <= in_day;
      year_r  <= in_year;
      rem_r   <= in_days;
      cent_r  <= cent_prod[ProdW-1 -: CentW];
      bad_r   <= 1'b0;
      ovf_r   <= 1'b0;
    end
    if (cmd.split) begin
      yic_r <= yic_diff[YicW-1:0];
    end
    if (cmd.check) begin
      bad_r <= date_bad;
    end
    if (cmd.step) begin
      if (rem_r > DaysW'(left)) begin
        rem_r <= rem_r - DaysW'(left) - DaysW'(1);
        day_r <= DayW'(1);
        if (month_r == DEC) begin
          if (year_r == MAX_YEAR) begin
            // Walking past the last representable year clamps the result.
            ovf_r   <= 1'b1;
            rem_r   <= '0;
            day_r   <= LAST_DAY_DEC;
          end else begin
            month_r <= JAN;
            year_r  <= year_r + YearW'(1);
            if (yic_r == LAST_YIC) begin
              yic_r  <= '0;
              cent_r <= cent_r + CentW'(1);
            end else begin
              yic_r  <= yic_r + YicW'(1);
            end
          end
        end else begin
          month_r <= month_r + MonthW'(1);
        end
      end else begin
        day_r <= day_r + rem_r[DayW-1:0];
        rem_r <= '0;
      end
    end
  end

  assign sts.bad      = bad_r;
  assign sts.rem_zero = (rem_r == '0);

  assign res.month = month_r;
  assign res.day   = day_r;
  assign res.year  = year_r;
  assign res.bad   = bad_r;
  assign res.ovf   = ovf_r;

endmodule

// File: sv/gregorian_date_add_days.sv
// ----------------------------------------------------------------------------
// Gregorian date adder
// Adds a day count to a month/day/year date, one month per cycle.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake           Contents
//  in_      in   in_tvalid/tready    start date and day count (one word)
//  out_     out  out_tvalid/tready   end date in tdata, flags in tuser
//
// A word passes through the split, check and walk states, then waits in the
// done state until emitted; the walk length is set by the single month-step
// loop in the datapath: every month boundary crossed takes a step, and so does
// the final landing in a month; the controller is idle once the result is valid.
// Items are handled one at a time; a new word is taken as soon as the
// controller is idle, even while the previous result waits in the output
// register. Reset is synchronous and active low and clears only control state.
// A stalled output holds the controller in its done state.
module gregorian_date_add_days import gda_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [3:0] start_month, [8:4] start_day, [22:9] start_year,
  // [38:23] days_to_add, [39] zero
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [3:0] end_month, [8:4] end_day, [22:9] end_year, [23] zero
  output logic [23:0] out_tdata,
  // [0] bad_input, [1] year_overflow
  output logic [1:0]  out_tuser
);

`include "gregorian_date_add_days_assert.svh"

  gda_cmd_t cmd;
  gda_sts_t sts;
  gda_res_t res;
  logic     emit;
  logic     out_free;

  logic        out_valid_r;
  logic [23:0] out_data_r;
  logic [1:0]  out_user_r;

  assign out_free = !out_valid_r || out_tready;

  gda_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .out_free (out_free),
    .sts      (sts),
    .cmd      (cmd),
    .emit     (emit)
  );

  gda_dp u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .in_month (in_tdata[3:0]),
    .in_day   (in_tdata[8:4]),
    .in_year  (in_tdata[22:9]),
    .in_days  (in_tdata[38:23]),
    .sts      (sts),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= {1'b0, res.year, res.day, res.month};
      out_user_r <= {res.ovf, res.bad};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `GDA_ASSERT_IMPL(a_emit_room, emit, out_free, "result emitted over an unread word")
  `GDA_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready,
                   "accepted while busy")
  `GDA_ASSERT_NEVER(a_flags_exclusive, out_tvalid && out_tuser[0] && out_tuser[1],
                    "both flags set")
  `GDA_ASSERT_IMPL(a_ovf_clamp, out_tvalid && out_tuser[1],
                   (out_tdata[3:0] == DEC) && (out_tdata[8:4] == LAST_DAY_DEC) &&
                   (out_tdata[22:9] == MAX_YEAR),
                   "overflow result not clamped")

endmodule
